// ===== hdl/dcr_pkg.sv =====
// Package with the shared types, register indexes and sizes of the disc cell rasterizer.
`default_nettype none
package dcr_pkg;

    localparam int MAX_BOX = 7;
    localparam int NUM_W   = 21;
    localparam int QUOT_W  = 22;

    localparam logic [2:0] CFG_RADIUS    = 3'd0;
    localparam logic [2:0] CFG_CELL_SIZE = 3'd1;
    localparam logic [2:0] CFG_X_BEGIN   = 3'd2;
    localparam logic [2:0] CFG_X_END     = 3'd3;
    localparam logic [2:0] CFG_Y_BEGIN   = 3'd4;
    localparam logic [2:0] CFG_Y_END     = 3'd5;

    typedef struct packed {
        logic signed [19:0] center_x;
        logic signed [19:0] center_y;
    } t_in;

    typedef struct packed {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic [15:0]        distance;
        logic               in_area;
        logic               in_border;
        logic               none_found;
        logic               truncated;
        logic               last;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_DIVGO, S_DIVW, S_BOX, S_R2, S_B2, S_B2W,
        S_XM, S_YM, S_XSQ, S_YSQ, S_SUM, S_SQRT, S_EMIT, S_NEXT, S_FIN, S_FLUSH
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/dcr_div.sv =====
// Iterative signed divider with floor remainder and rounding half to even.
`default_nettype none
module dcr_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [dcr_pkg::NUM_W-1:0]    i_num,
    input  wire logic [15:0]                         i_den,
    output logic                                     o_done,
    output logic signed [dcr_pkg::QUOT_W-1:0]        o_quot
);
    import dcr_pkg::*;

    logic [NUM_W-1:0] r_q;
    logic [15:0]      r_rem;
    logic             r_neg;
    logic [4:0]       r_cnt;
    logic             r_post;
    logic [16:0]      trial;
    logic             ge;
    logic signed [QUOT_W-1:0] qs;
    logic [16:0]      rr;
    logic [17:0]      two_r;
    logic [NUM_W-1:0] mag;

    assign mag   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign trial = {r_rem, r_q[NUM_W-1]};
    assign ge    = trial >= {1'b0, i_den};

    always_comb begin
        if (r_neg && r_rem != 16'd0) begin
            qs = -$signed({1'b0, r_q}) - QUOT_W'(1);
            rr = {1'b0, i_den} - {1'b0, r_rem};
        end else if (r_neg) begin
            qs = -$signed({1'b0, r_q});
            rr = 17'd0;
        end else begin
            qs = $signed({1'b0, r_q});
            rr = {1'b0, r_rem};
        end
        two_r = {rr, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 5'd0;
            r_post <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_neg  <= i_num[NUM_W-1];
                r_q    <= mag;
                r_rem  <= 16'd0;
                r_cnt  <= 5'(NUM_W);
            end else if (r_cnt != 5'd0) begin
                r_rem <= ge ? 16'(trial - {1'b0, i_den}) : trial[15:0];
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_cnt <= r_cnt - 5'd1;
                r_post <= (r_cnt == 5'd1);
            end else if (r_post) begin
                r_post <= 1'b0;
                o_done <= 1'b1;
                if (two_r > {2'b0, i_den} || (two_r == {2'b0, i_den} && qs[0])) begin
                    o_quot <= qs + QUOT_W'(1);
                end else begin
                    o_quot <= qs;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/dcr_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module dcr_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_val,
    output logic             o_done,
    output logic [15:0]      o_root
);
    import dcr_pkg::*;

    logic [31:0] r_val;
    logic [17:0] r_rem;
    logic [4:0]  r_cnt;
    logic [17:0] rem_sh;
    logic [17:0] trial;

    assign rem_sh = {r_rem[15:0], r_val[31:30]};
    assign trial  = {o_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 5'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_val  <= i_val;
                r_rem  <= 18'd0;
                o_root <= 16'd0;
                r_cnt  <= 5'd16;
            end else if (r_cnt != 5'd0) begin
                r_val <= {r_val[29:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    o_root <= {o_root[14:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    o_root <= {o_root[14:0], 1'b0};
                end
                r_cnt  <= r_cnt - 5'd1;
                o_done <= (r_cnt == 5'd1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/disc_cell_rasterizer.sv =====
// Top level of the disc cell rasterizer: registers, sequencer, shared multiplier and output stage.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | i_valid, o_ready, i_data             | in
//  output   | o_valid, i_ready, o_data             | out
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data      | in
//
// Each center runs six divisions and setup, then scans each cell in its box and runs a square
// root for each area cell. The shared divider, multiplier and square root unit do this work.
// Reset is synchronous and active low; it clears control state and sets the registers.
// A stalled output holds the sequencer only when a new result must be placed.
`default_nettype none
module disc_cell_rasterizer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire dcr_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output dcr_pkg::t_out     o_data,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data
);
    import dcr_pkg::*;

    function automatic logic signed [15:0] clamp(input logic signed [15:0] lo,
                                                 input logic signed [QUOT_W-1:0] v,
                                                 input logic signed [15:0] hi);
        logic signed [15:0] res;
        if (v < QUOT_W'(lo)) begin
            res = lo;
        end else if (v > QUOT_W'(hi)) begin
            res = hi;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    logic [15:0]        r_radius, r_csize;
    logic signed [15:0] r_xb, r_xe, r_yb, r_ye;
    t_state             r_state, n_state;
    logic signed [19:0] r_cx, r_cy;
    logic [2:0]         r_dk;
    logic signed [15:0] r_x0, r_x1, r_y0, r_y1, r_xstop, r_ystop, r_ix, r_iy;
    logic signed [QUOT_W-1:0] r_rx, r_ry;
    logic               r_trunc, r_allb, r_far, r_any_area, r_any_border, r_fin;
    logic [31:0]        r_r2, r_b2, r_sum;
    logic [15:0]        r_ax, r_ay;
    logic signed [35:0] r_prod;
    t_out               r_cell, r_pend, r_out;
    logic               r_pend_v, r_out_v;

    logic [15:0]        s_eff;
    logic signed [17:0] mul_a, mul_b;
    logic signed [NUM_W-1:0] div_num;
    logic               div_start, div_done;
    logic signed [QUOT_W-1:0] div_q;
    logic               sq_start, sq_done;
    logic [15:0]        sq_root;
    logic signed [35:0] dd;
    logic [35:0]        dabs;
    logic [32:0]        sum;
    logic               out_free;
    logic signed [16:0] diffx, diffy;
    logic signed [15:0] ix_nx, iy_nx;
    logic               repair_in;
    t_out               pend_last;

    assign s_eff    = (r_csize == 16'd0) ? 16'd1 : r_csize;
    assign out_free = !r_out_v || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_v;
    assign o_data   = r_out;

    always_comb begin
        pend_last      = r_pend;
        pend_last.last = 1'b1;
    end

    always_comb begin
        case (r_dk)
            3'd0:    div_num = NUM_W'(r_cx) - $signed({5'b0, r_radius});
            3'd1:    div_num = NUM_W'(r_cx) + $signed({5'b0, r_radius});
            3'd2:    div_num = NUM_W'(r_cy) - $signed({5'b0, r_radius});
            3'd3:    div_num = NUM_W'(r_cy) + $signed({5'b0, r_radius});
            3'd4:    div_num = NUM_W'(r_cx);
            default: div_num = NUM_W'(r_cy);
        endcase
    end

    dcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (s_eff),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    dcr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sum[31:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_comb begin
        case (r_state)
            S_R2:    begin mul_a = $signed({2'b0, r_radius}); mul_b = mul_a; end
            S_B2:    begin
                mul_a = $signed({2'b0, r_radius}) - $signed({2'b0, s_eff});
                mul_b = mul_a;
            end
            S_XM:    begin mul_a = 18'(r_ix); mul_b = $signed({2'b0, s_eff}); end
            S_YM:    begin mul_a = 18'(r_iy); mul_b = $signed({2'b0, s_eff}); end
            S_XSQ:   begin mul_a = $signed({2'b0, r_ax}); mul_b = mul_a; end
            S_YSQ:   begin mul_a = $signed({2'b0, r_ay}); mul_b = mul_a; end
            default: begin mul_a = 18'sd0; mul_b = 18'sd0; end
        endcase
        dd    = r_prod - 36'((r_state == S_YM) ? r_cx : r_cy);
        dabs  = dd[35] ? 36'(-dd) : 36'(dd);
        sum   = {1'b0, r_sum} + {1'b0, r_prod[31:0]};
        diffx = 17'(r_x1) - 17'(r_x0);
        diffy = 17'(r_y1) - 17'(r_y0);
        ix_nx = r_ix + 16'sd1;
        iy_nx = r_iy + 16'sd1;
        repair_in = (r_rx >= QUOT_W'(r_xb)) && (r_rx < QUOT_W'(r_xe)) &&
                    (r_ry >= QUOT_W'(r_yb)) && (r_ry < QUOT_W'(r_ye));
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        sq_start  = 1'b0;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_DIVGO;
            S_DIVGO: begin
                div_start = 1'b1;
                n_state   = S_DIVW;
            end
            S_DIVW:  if (div_done) n_state = (r_dk == 3'd5) ? S_BOX : S_DIVGO;
            S_BOX:   n_state = S_R2;
            S_R2:    n_state = S_B2;
            S_B2:    n_state = S_B2W;
            S_B2W:   n_state = (r_x0 < r_xstop && r_y0 < r_ystop) ? S_XM : S_FIN;
            S_XM:    n_state = S_YM;
            S_YM:    n_state = S_XSQ;
            S_XSQ:   n_state = (r_far || dabs[35:16] != 20'd0) ? S_NEXT : S_YSQ;
            S_YSQ:   n_state = S_SUM;
            S_SUM:   begin
                if (sum > {1'b0, r_r2}) begin
                    n_state = S_NEXT;
                end else begin
                    sq_start = 1'b1;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT:  if (sq_done) n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = r_fin ? S_FLUSH : S_NEXT;
            S_NEXT:  begin
                if (iy_nx < r_ystop || ix_nx < r_xstop) begin
                    n_state = S_XM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = (!r_any_area || !r_any_border) ? S_EMIT : S_FLUSH;
            S_FLUSH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd512;
            r_csize  <= 16'd256;
            r_xb     <= -16'sd32768;
            r_xe     <= 16'sd32767;
            r_yb     <= -16'sd32768;
            r_ye     <= 16'sd32767;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS:    r_radius <= i_cfg_data;
                CFG_CELL_SIZE: r_csize  <= i_cfg_data;
                CFG_X_BEGIN:   r_xb     <= $signed(i_cfg_data);
                CFG_X_END:     r_xe     <= $signed(i_cfg_data);
                CFG_Y_BEGIN:   r_yb     <= $signed(i_cfg_data);
                CFG_Y_END:     r_ye     <= $signed(i_cfg_data);
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 36'(mul_a * mul_b);
        case (r_state)
            S_IDLE: begin
                r_cx <= i_data.center_x;
                r_cy <= i_data.center_y;
                r_dk <= 3'd0;
            end
            S_DIVW: begin
                if (div_done) begin
                    r_dk <= r_dk + 3'd1;
                    case (r_dk)
                        3'd0:    r_x0 <= clamp(r_xb, div_q, r_xe);
                        3'd1:    r_x1 <= clamp(r_xb, div_q, r_xe);
                        3'd2:    r_y0 <= clamp(r_yb, div_q, r_ye);
                        3'd3:    r_y1 <= clamp(r_yb, div_q, r_ye);
                        3'd4:    r_rx <= div_q;
                        default: r_ry <= div_q;
                    endcase
                end
            end
            S_BOX: begin
                r_trunc <= (diffx > 17'(MAX_BOX)) || (diffy > 17'(MAX_BOX));
                r_xstop <= (diffx > 17'(MAX_BOX)) ? r_x0 + 16'(MAX_BOX) : r_x1;
                r_ystop <= (diffy > 17'(MAX_BOX)) ? r_y0 + 16'(MAX_BOX) : r_y1;
            end
            S_B2: r_r2 <= r_prod[31:0];
            S_B2W: begin
                r_b2         <= r_prod[31:0];
                r_allb       <= r_radius <= s_eff;
                r_ix         <= r_x0;
                r_iy         <= r_y0;
                r_any_area   <= 1'b0;
                r_any_border <= 1'b0;
                r_fin        <= 1'b0;
            end
            S_YM: begin
                r_ax  <= dabs[15:0];
                r_far <= dabs[35:16] != 20'd0;
            end
            S_XSQ: r_ay <= dabs[15:0];
            S_YSQ: r_sum <= r_prod[31:0];
            S_SUM: r_sum <= sum[31:0];
            S_SQRT: begin
                if (sq_done) begin
                    r_cell.cell_x     <= r_ix;
                    r_cell.cell_y     <= r_iy;
                    r_cell.distance   <= sq_root;
                    r_cell.in_area    <= 1'b1;
                    r_cell.in_border  <= r_allb || r_sum >= r_b2;
                    r_cell.none_found <= 1'b0;
                    r_cell.truncated  <= r_trunc;
                    r_cell.last       <= 1'b0;
                    r_any_area        <= 1'b1;
                    r_any_border      <= r_any_border || r_allb || r_sum >= r_b2;
                end
            end
            S_NEXT: begin
                if (iy_nx < r_ystop) begin
                    r_iy <= iy_nx;
                end else begin
                    r_iy <= r_y0;
                    r_ix <= ix_nx;
                end
            end
            S_FIN: begin
                r_fin            <= 1'b1;
                r_cell.distance  <= 16'd0;
                r_cell.truncated <= r_trunc;
                r_cell.last      <= 1'b0;
                if (repair_in) begin
                    r_cell.cell_x     <= r_rx[15:0];
                    r_cell.cell_y     <= r_ry[15:0];
                    r_cell.in_area    <= !r_any_area;
                    r_cell.in_border  <= 1'b1;
                    r_cell.none_found <= 1'b0;
                end else begin
                    r_cell.cell_x     <= 16'sd0;
                    r_cell.cell_y     <= 16'sd0;
                    r_cell.in_area    <= 1'b0;
                    r_cell.in_border  <= 1'b0;
                    r_cell.none_found <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_pend   <= r_cell;
            r_pend_v <= 1'b1;
            r_out    <= r_pend;
            r_out_v  <= r_pend_v;
        end else if (r_state == S_FLUSH && out_free) begin
            r_out      <= pend_last;
            r_out_v    <= 1'b1;
            r_pend_v   <= 1'b0;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.none_found |->
            o_data.cell_x == 16'sd0 && o_data.cell_y == 16'sd0 && !o_data.in_area)
        else $error("none_found transaction carries a cell");

    a_repair_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.in_area && !o_data.none_found |->
            o_data.in_border && o_data.distance == 16'd0 && o_data.last)
        else $error("repair transaction malformed");

    a_scan_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_XM |-> r_ix < r_xstop && r_iy < r_ystop)
        else $error("scan index outside the box");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FLUSH |-> r_pend_v)
        else $error("flush without a pending result");

endmodule
`default_nettype wire

// ===== test/dcr_checker.sv =====
// Checker for the disc cell rasterizer: predicts the cells of each center and compares results.
`timescale 1ns / 1ps
module dcr_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  dcr_pkg::t_in      i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  dcr_pkg::t_out     i_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    import dcr_pkg::*;

    logic [15:0] radius_q, cell_size_q;
    logic signed [15:0] x_begin_q, x_end_q, y_begin_q, y_end_q;
    t_out expected_cells[$];

    function automatic longint div_round_even(longint n, longint d);
        longint q, r;
        q = n / d;
        r = n % d;
        if (r < 0) begin
            q = q - 1;
            r = r + d;
        end
        if (2 * r > d) q = q + 1;
        else if (2 * r == d && q[0]) q = q + 1;
        return q;
    endfunction

    function automatic longint clamp_index(longint lo, longint v, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void predict_disc_cells(t_in c);
        longint cx, cy, r, s, xb, xe, yb, ye, ix0, ix1, iy0, iy1, xstop, ystop;
        longint dx, dy, xx, yy;
        longint unsigned r2, b2, sum;
        bit all_border, trunc, border;
        int n_area, n_border;
        t_out o;
        cx = longint'(c.center_x);
        cy = longint'(c.center_y);
        r = longint'(radius_q);
        s = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
        xb = x_begin_q; xe = x_end_q; yb = y_begin_q; ye = y_end_q;
        ix0 = clamp_index(xb, div_round_even(cx - r, s), xe);
        ix1 = clamp_index(xb, div_round_even(cx + r, s), xe);
        iy0 = clamp_index(yb, div_round_even(cy - r, s), ye);
        iy1 = clamp_index(yb, div_round_even(cy + r, s), ye);
        xstop = ix1;
        ystop = iy1;
        trunc = 0;
        r2 = r * r;
        all_border = (r <= s);
        b2 = all_border ? 0 : (r - s) * (r - s);
        n_area = 0;
        n_border = 0;
        if (ix1 - ix0 > MAX_BOX) begin
            xstop = ix0 + MAX_BOX;
            trunc = 1;
        end
        if (iy1 - iy0 > MAX_BOX) begin
            ystop = iy0 + MAX_BOX;
            trunc = 1;
        end
        for (longint ix = ix0; ix < xstop; ix++) begin
            for (longint iy = iy0; iy < ystop; iy++) begin
                dx = ix * s - cx;
                dy = iy * s - cy;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx > 65535 || dy > 65535) continue;
                sum = dx * dx + dy * dy;
                if (sum > r2) continue;
                border = all_border || sum >= b2;
                o = '0;
                o.cell_x = ix[15:0];
                o.cell_y = iy[15:0];
                o.distance = 16'(int_sqrt(sum));
                o.in_area = 1;
                o.in_border = border;
                o.truncated = trunc;
                expected_cells.insert(expected_cells.size(), o);
                n_area++;
                if (border) n_border++;
            end
        end
        if (n_area == 0 || n_border == 0) begin
            xx = div_round_even(cx, s);
            yy = div_round_even(cy, s);
            o = '0;
            o.truncated = trunc;
            if (xx >= xb && xx < xe && yy >= yb && yy < ye) begin
                o.cell_x = xx[15:0];
                o.cell_y = yy[15:0];
                o.in_area = (n_area == 0);
                o.in_border = 1;
            end else begin
                o.none_found = 1;
            end
            expected_cells.insert(expected_cells.size(), o);
        end
        expected_cells[$].last = 1;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            radius_q <= 16'd512;
            cell_size_q <= 16'd256;
            x_begin_q <= -16'sd32768;
            x_end_q <= 16'sd32767;
            y_begin_q <= -16'sd32768;
            y_end_q <= 16'sd32767;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_cells.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("Unexpected result transaction: %p", i_out_data);
                end else begin
                    want = expected_cells.pop_front();
                    if (want != i_out_data) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display("Result mismatch: expected %p, actual %p", want,
                                     i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_disc_cells(i_in_data);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:    radius_q <= i_cfg_data;
                    CFG_CELL_SIZE: cell_size_q <= i_cfg_data;
                    CFG_X_BEGIN:   x_begin_q <= i_cfg_data;
                    CFG_X_END:     x_end_q <= i_cfg_data;
                    CFG_Y_BEGIN:   y_begin_q <= i_cfg_data;
                    CFG_Y_END:     y_end_q <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_cells.size();
    end

endmodule

// ===== test/tb_disc_cell_rasterizer.sv =====
// Testbench top for the disc cell rasterizer: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_disc_cell_rasterizer;
    import dcr_pkg::*;

    localparam int SETTLE_CYCLES = 1500;
    localparam int STALL_LIMIT   = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    t_in in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    t_out out_data;
    logic cfg_we = 0;
    logic [2:0] cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    int errors, pending;
    bit quiet = 0;
    bit hold_req = 0;
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    disc_cell_rasterizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_data),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    dcr_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ready = 0;
                repeat (400) @(negedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ready = 0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                out_ready = 1;
            end
        end
    end

    task automatic send_center(input logic [19:0] x, input logic [19:0] y);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid = 0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_data.center_x = x;
        in_data.center_y = y;
        in_valid = 1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we = 1;
        cfg_idx = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 0;
    endtask

    task automatic drain_results();
        in_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_bounds(input logic [15:0] xb, input logic [15:0] xe,
                              input logic [15:0] yb, input logic [15:0] ye);
        write_reg(CFG_X_BEGIN, xb);
        write_reg(CFG_X_END, xe);
        write_reg(CFG_Y_BEGIN, yb);
        write_reg(CFG_Y_END, ye);
    endtask

    task automatic random_centers(input int count, input int spread);
        logic [19:0] x, y;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                x = 20'($urandom);
                y = 20'($urandom);
            end else begin
                x = 20'($signed($urandom_range(0, 2 * spread)) - spread);
                y = 20'($signed($urandom_range(0, 2 * spread)) - spread);
            end
            send_center(x, y);
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;

        send_center(20'd0, 20'd0);
        send_center(20'h80000, 20'h80000);
        send_center(20'h7FFFF, 20'h7FFFF);
        send_center(20'd128, 20'd384);
        send_center(20'hFFF80, 20'hFFE80);
        send_center(20'd300, 20'hFFD00);
        drain_results();

        write_reg(CFG_RADIUS, 16'd0);
        send_center(20'd128, 20'd640);
        send_center(20'd77, 20'hFFF11);
        drain_results();

        write_reg(CFG_CELL_SIZE, 16'd0);
        write_reg(CFG_RADIUS, 16'd3);
        send_center(20'd1000, 20'hFFC00);
        drain_results();
        write_reg(CFG_RADIUS, 16'd65535);
        write_reg(CFG_CELL_SIZE, 16'd65535);
        send_center(20'd0, 20'd0);
        send_center(20'h7FFFF, 20'h80000);
        drain_results();
        write_reg(CFG_CELL_SIZE, 16'd256);
        write_reg(CFG_RADIUS, 16'd2560);
        send_center(20'd500, 20'hFFA00);
        drain_results();

        set_bounds(16'd10, 16'hFFF6, 16'hFFFB, 16'd5);
        send_center(20'd0, 20'd0);
        drain_results();
        set_bounds(16'hFFFE, 16'd2, 16'hFFFE, 16'd2);
        write_reg(CFG_RADIUS, 16'd512);
        send_center(20'd0, 20'd0);
        send_center(20'd2048, 20'd0);
        send_center(20'd512, 20'hFFE00);
        drain_results();
        write_reg(CFG_RADIUS, 16'd1000);
        send_center(20'd256, 20'd0);
        drain_results();

        set_bounds(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        write_reg(CFG_RADIUS, 16'd700);
        write_reg(CFG_CELL_SIZE, 16'd300);
        hold_req = 1;
        random_centers(25, 20000);
        drain_results();

        write_reg(CFG_RADIUS, 16'd100);
        write_reg(CFG_CELL_SIZE, 16'd256);
        set_bounds(16'hFFF0, 16'd16, 16'hFFF0, 16'd16);
        random_centers(25, 5000);
        drain_results();

        write_reg(CFG_RADIUS, 16'($urandom_range(200, 1500)));
        write_reg(CFG_CELL_SIZE, 16'($urandom_range(256, 800)));
        set_bounds(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        random_centers(25, 524287);
        drain_results();

        quiet = 1;
        write_reg(CFG_RADIUS, 16'd1200);
        write_reg(CFG_CELL_SIZE, 16'd400);
        random_centers(25, 3000);
        drain_results();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
